// ===== sv/lfe_pkg.sv =====
// Shared constants, codes and interface types of the LRU/FIFO evictor.
`default_nettype none

package lfe_pkg;

    localparam int ENTRIES     = 32;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_W      = 5;
    localparam int TIME_W      = 62;
    localparam int SIZE_W      = 32;
    localparam int TOTAL_W     = 37;
    localparam int FREED_W     = TOTAL_W + 1;
    localparam int IN_DATA_W   = 200;
    localparam int OUT_DATA_W  = 40;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_INVAL = 2'd1;
    localparam logic [1:0] ACT_EVICT = 2'd2;

    localparam logic [1:0] ST_EVICTED = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    typedef struct packed {
        logic              mem_en;
        logic              valid_en;
        logic              valid_val;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] created;
        logic [TIME_W-1:0] used;
        logic [SIZE_W-1:0] size;
        logic              evictable;
    } lfe_wr_t;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] size;
    } lfe_best_t;

endpackage

`default_nettype wire

// ===== sv/lfe_table.sv =====
// Entry table: time and size memories plus valid and evictable flags.
`default_nettype none

module lfe_table
    import lfe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lfe_wr_t           wr,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output logic      [TIME_W-1:0] rd_created,
    output logic      [TIME_W-1:0] rd_used,
    output logic      [SIZE_W-1:0] rd_size,
    input  wire logic [IDX_W-1:0]  flag_idx,
    output logic                   flag_valid,
    output logic                   flag_evictable
);

    logic [TIME_W-1:0]  mem_created [ENTRIES];
    logic [TIME_W-1:0]  mem_used    [ENTRIES];
    logic [SIZE_W-1:0]  mem_size    [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] evictable_reg;

    always_ff @(posedge clk)
    begin
        if (wr.mem_en)
        begin
            mem_created[wr.idx] <= wr.created;
            mem_used[wr.idx]    <= wr.used;
            mem_size[wr.idx]    <= wr.size;
            evictable_reg[wr.idx] <= wr.evictable;
        end
        if (rd_en)
        begin
            rd_created <= mem_created[rd_addr];
            rd_used    <= mem_used[rd_addr];
            rd_size    <= mem_size[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.valid_en)
        begin
            valid_reg[wr.idx] <= wr.valid_val;
        end
    end

    assign flag_valid     = valid_reg[flag_idx];
    assign flag_evictable = evictable_reg[flag_idx];

endmodule

`default_nettype wire

// ===== sv/lfe_cmp.sv =====
// Shared key comparator that tracks the oldest candidate of one table scan.
`default_nettype none

module lfe_cmp
    import lfe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clear,
    input  wire logic              en,
    input  wire logic              ok,
    input  wire logic [IDX_W-1:0]  idx,
    input  wire logic [TIME_W-1:0] key,
    input  wire logic [SIZE_W-1:0] size,
    output lfe_best_t              best
);

    logic              found_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TIME_W-1:0] key_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              take;

    // Strictly older wins, so the lowest slot keeps a tie on an ascending scan.
    assign take = en && ok && (!found_reg || (key < key_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !clear)
        begin
            idx_reg  <= idx;
            key_reg  <= key;
            size_reg <= size;
        end
    end

    assign best.found = found_reg;
    assign best.idx   = idx_reg;
    assign best.size  = size_reg;

endmodule

`default_nettype wire

// ===== sv/lru_fifo_evictor_top.sv =====
// Top level of the LRU/FIFO evictor: sequencer, byte totals and output register.
//
// Input words arrive on the s_axis channel, the action code in tuser. A write or
// invalidate updates one table slot and gives no result. An evict request
// either answers at once (refused, or nothing to free) or runs victim searches:
// each search scans all ENTRIES slots through one comparator. Each evicted entry
// gives one output word; the final word of a request carries tlast. The input
// side is not ready while a request or a table update is in progress. Results
// leave through a one-word output register; when the receiver stalls, the search
// holds before emitting the next word, and the next input word may be taken
// while the final word still waits.
// The policy register selects LRU (0) or FIFO (1) and is written through
// policy_we. The user must write it only while the block is idle; the block
// itself does not enforce this.
// Reset clears all valid marks, the stored byte total and the policy.
`default_nettype none

module lru_fifo_evictor_top
    import lfe_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  policy_we,
    input  wire logic                  policy_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0: slot, created_sec, created_nsec, used_sec, used_nsec,
    // entry_bytes, can_evict, amount_to_free.
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: action.
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Fields from bit 0: evicted_slot, evicted_bytes.
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // Fields from bit 0: status.
    output logic [1:0]                 m_axis_tuser,
    output logic                       m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR_SUB,
        S_WR_ADD,
        S_EV_CHECK,
        S_SCAN,
        S_PICK,
        S_FLUSH
    } state_t;

    state_t              state_reg;
    logic                policy_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic                is_write_reg;
    logic [TIME_W-1:0]   created_reg;
    logic [TIME_W-1:0]   used_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic                evict_flag_reg;
    logic [TOTAL_W-1:0]  amount_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [FREED_W-1:0]  freed_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [31:0]         count_reg;
    logic [IDX_W:0]      scan_reg;
    logic                cmp_en_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                pend_reg;
    logic [1:0]          pend_status_reg;
    logic [IDX_W-1:0]    pend_slot_reg;
    logic [SIZE_W-1:0]   pend_bytes_reg;
    logic                out_valid_reg;
    logic [1:0]          out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [SIZE_W-1:0]   out_bytes_reg;
    logic                out_last_reg;

    logic                accept;
    logic [1:0]          in_action;
    logic [SLOT_W-1:0]   in_slot;
    logic                slot_ok;
    logic                out_free;
    logic                pick_go;
    logic                pick_done;
    logic                cmp_clear;
    logic [TIME_W-1:0]   key;
    logic [SIZE_W-1:0]   sub_src;
    logic [TOTAL_W-1:0]  total_minus;
    logic [FREED_W-1:0]  total_sum;
    logic [TOTAL_W-1:0]  total_plus;
    logic [FREED_W-1:0]  freed_add;
    logic [CNT_W-1:0]    n_inc;
    logic                tbl_rd_en;
    logic [IDX_W-1:0]    tbl_rd_addr;
    logic [TIME_W-1:0]   rd_created;
    logic [TIME_W-1:0]   rd_used;
    logic [SIZE_W-1:0]   rd_size;
    logic [IDX_W-1:0]    flag_idx;
    logic                flag_valid;
    logic                flag_evictable;
    lfe_wr_t             wr;
    lfe_best_t           best;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_action     = s_axis_tuser;
    assign in_slot       = s_axis_tdata[4:0];
    assign slot_ok       = (int'(in_slot) < ENTRIES);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign pick_go       = !pend_reg || out_free;
    assign key           = policy_reg ? rd_created : rd_used;

    always_comb
    begin
        sub_src     = (state_reg == S_PICK) ? best.size : rd_size;
        total_minus = (FREED_W'(sub_src) > FREED_W'(total_reg))
                      ? '0 : total_reg - TOTAL_W'(sub_src);
        total_sum   = FREED_W'(total_reg) + FREED_W'(size_reg);
        total_plus  = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        freed_add   = freed_reg + FREED_W'(best.size);
        n_inc       = n_reg + CNT_W'(1);
        pick_done   = (freed_add >= FREED_W'(amount_reg)) || (n_inc == CNT_W'(MAX_RESULTS));
        cmp_clear   = (state_reg == S_EV_CHECK) || ((state_reg == S_PICK) && pick_go);
    end

    always_comb
    begin
        tbl_rd_en   = accept || ((state_reg == S_SCAN) && (int'(scan_reg) < ENTRIES));
        tbl_rd_addr = (state_reg == S_IDLE) ? IDX_W'(in_slot) : scan_reg[IDX_W-1:0];

        unique case (state_reg)
            S_WR_SUB: flag_idx = slot_reg;
            S_PICK:   flag_idx = best.idx;
            default:  flag_idx = cmp_idx_reg;
        endcase

        wr.mem_en    = (state_reg == S_WR_SUB) && is_write_reg;
        wr.valid_en  = (state_reg == S_WR_SUB)
                       || ((state_reg == S_PICK) && pick_go && best.found);
        wr.valid_val = (state_reg == S_WR_SUB) && is_write_reg;
        wr.idx       = (state_reg == S_PICK) ? best.idx : slot_reg;
        wr.created   = created_reg;
        wr.used      = used_reg;
        wr.size      = size_reg;
        wr.evictable = evict_flag_reg;
    end

    lfe_table u_table (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr             (wr),
        .rd_en          (tbl_rd_en),
        .rd_addr        (tbl_rd_addr),
        .rd_created     (rd_created),
        .rd_used        (rd_used),
        .rd_size        (rd_size),
        .flag_idx       (flag_idx),
        .flag_valid     (flag_valid),
        .flag_evictable (flag_evictable)
    );

    lfe_cmp u_cmp (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cmp_clear),
        .en    (cmp_en_reg),
        .ok    (flag_valid && flag_evictable),
        .idx   (cmp_idx_reg),
        .key   (key),
        .size  (rd_size),
        .best  (best)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= 1'b0;
            total_reg     <= '0;
            freed_reg     <= '0;
            n_reg         <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            cmp_en_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (policy_we)
            begin
                policy_reg <= policy_wdata;
            end
            cmp_en_reg  <= (state_reg == S_SCAN) && (int'(scan_reg) < ENTRIES);
            cmp_idx_reg <= scan_reg[IDX_W-1:0];
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        slot_reg       <= IDX_W'(in_slot);
                        is_write_reg   <= (in_action == ACT_WRITE);
                        created_reg    <= {s_axis_tdata[36:5], s_axis_tdata[66:37]};
                        used_reg       <= {s_axis_tdata[98:67], s_axis_tdata[128:99]};
                        size_reg       <= s_axis_tdata[160:129];
                        evict_flag_reg <= s_axis_tdata[161];
                        amount_reg     <= s_axis_tdata[198:162];
                        if (in_action == ACT_EVICT)
                        begin
                            state_reg <= S_EV_CHECK;
                        end
                        else if (((in_action == ACT_WRITE) || (in_action == ACT_INVAL))
                                 && slot_ok)
                        begin
                            state_reg <= S_WR_SUB;
                        end
                    end
                end
                S_WR_SUB:
                begin
                    if (flag_valid)
                    begin
                        total_reg <= total_minus;
                    end
                    state_reg <= is_write_reg ? S_WR_ADD : S_IDLE;
                end
                S_WR_ADD:
                begin
                    total_reg <= total_plus;
                    state_reg <= S_IDLE;
                end
                S_EV_CHECK:
                begin
                    freed_reg      <= '0;
                    n_reg          <= '0;
                    pend_reg       <= 1'b0;
                    scan_reg       <= '0;
                    pend_slot_reg  <= '0;
                    pend_bytes_reg <= '0;
                    if (amount_reg > total_reg)
                    begin
                        pend_status_reg <= ST_REFUSED;
                        state_reg       <= S_FLUSH;
                    end
                    else if (amount_reg == '0)
                    begin
                        pend_status_reg <= ST_NONE;
                        state_reg       <= S_FLUSH;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    scan_reg <= scan_reg + (IDX_W + 1)'(1);
                    if (int'(scan_reg) == ENTRIES)
                    begin
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    if (!best.found)
                    begin
                        if (!pend_reg)
                        begin
                            pend_status_reg <= ST_NONE;
                            pend_slot_reg   <= '0;
                            pend_bytes_reg  <= '0;
                        end
                        state_reg <= S_FLUSH;
                    end
                    else if (pick_go)
                    begin
                        if (pend_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= ST_EVICTED;
                            out_slot_reg   <= SLOT_W'(pend_slot_reg);
                            out_bytes_reg  <= pend_bytes_reg;
                            out_last_reg   <= 1'b0;
                        end
                        pend_reg        <= 1'b1;
                        pend_status_reg <= ST_EVICTED;
                        pend_slot_reg   <= best.idx;
                        pend_bytes_reg  <= best.size;
                        total_reg       <= total_minus;
                        freed_reg       <= freed_add;
                        n_reg           <= n_inc;
                        count_reg       <= count_reg + 32'd1;
                        scan_reg        <= '0;
                        state_reg       <= pick_done ? S_FLUSH : S_SCAN;
                    end
                end
                S_FLUSH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= pend_status_reg;
                        out_slot_reg   <= SLOT_W'(pend_slot_reg);
                        out_bytes_reg  <= pend_bytes_reg;
                        out_last_reg   <= 1'b1;
                        pend_reg       <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_bytes_reg, out_slot_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_victim_is_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK) && best.found |-> flag_valid && flag_evictable)
        else $error("chosen victim is not a valid evictable entry");

    a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(MAX_RESULTS))
        else $error("more results than allowed in one request");

    a_empty_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_EVICTED) |-> (m_axis_tdata == '0) && m_axis_tlast)
        else $error("non-eviction word carries payload or lacks last");

    a_no_pending_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_reg)
        else $error("pending victim left behind at end of request");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/lru_fifo_evictor_top_tb.sv =====
// Self-checking testbench for the LRU/FIFO evictor, with directed and random table traffic.
module lru_fifo_evictor_top_tb;
    import lfe_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int STALL_MAX = 13;
    localparam int PAUSE_CYCLES = 6;
    localparam int FINAL_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES = 6;
    localparam int WORDS_PER_PHASE = 52;

    typedef struct packed {
        logic [1:0]         action;
        logic [SLOT_W-1:0]  slot;
        logic [31:0]        created_sec;
        logic [29:0]        created_nsec;
        logic [31:0]        used_sec;
        logic [29:0]        used_nsec;
        logic [SIZE_W-1:0]  entry_bytes;
        logic               can_evict;
        logic [TOTAL_W-1:0] amount;
    } table_op_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] bytes;
        logic              last;
    } eviction_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  policy_we = 1'b0;
    logic                  policy_wdata = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    logic                  order_fifo = 1'b0;
    logic [ENTRIES-1:0]    slot_valid = '0;
    logic [ENTRIES-1:0]    slot_evictable = '0;
    logic [TIME_W-1:0]     slot_created [ENTRIES];
    logic [TIME_W-1:0]     slot_used [ENTRIES];
    logic [SIZE_W-1:0]     slot_size [ENTRIES];
    logic [TOTAL_W-1:0]    stored_bytes = '0;
    eviction_t             expected_evictions [$];
    int                    mismatches = 0;
    int                    rx_hold = 0;
    bit                    idle_on = 1'b1;

    lru_fifo_evictor_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .policy_we    (policy_we),
        .policy_wdata (policy_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_eviction(input table_op_t op);
        logic [TOTAL_W:0]  freed;
        logic [TOTAL_W:0]  sum;
        logic [TIME_W-1:0] key;
        logic [TIME_W-1:0] best_key;
        eviction_t         held;
        bit                have_held;
        int                victim;
        int                count;
        if (op.action == ACT_WRITE || op.action == ACT_INVAL)
        begin
            if (slot_valid[op.slot])
            begin
                stored_bytes = (slot_size[op.slot] > stored_bytes) ? '0
                               : stored_bytes - slot_size[op.slot];
                slot_valid[op.slot] = 1'b0;
            end
            if (op.action == ACT_WRITE)
            begin
                slot_valid[op.slot] = 1'b1;
                slot_created[op.slot] = {op.created_sec, op.created_nsec};
                slot_used[op.slot] = {op.used_sec, op.used_nsec};
                slot_size[op.slot] = op.entry_bytes;
                slot_evictable[op.slot] = op.can_evict;
                sum = {1'b0, stored_bytes} + op.entry_bytes;
                stored_bytes = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            end
        end
        else if (op.action == ACT_EVICT)
        begin
            if (op.amount > stored_bytes)
            begin
                expected_evictions.push_back('{ST_REFUSED, '0, '0, 1'b1});
            end
            else
            begin
                freed = '0;
                count = 0;
                have_held = 1'b0;
                held = '0;
                while (freed < op.amount && count < MAX_RESULTS)
                begin
                    victim = -1;
                    best_key = '0;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (slot_valid[i] && slot_evictable[i])
                        begin
                            key = order_fifo ? slot_created[i] : slot_used[i];
                            if (victim < 0 || key < best_key)
                            begin
                                victim = i;
                                best_key = key;
                            end
                        end
                    end
                    if (victim < 0)
                        break;
                    slot_valid[victim] = 1'b0;
                    stored_bytes = (slot_size[victim] > stored_bytes) ? '0
                                   : stored_bytes - slot_size[victim];
                    freed = freed + slot_size[victim];
                    if (have_held)
                        expected_evictions.push_back(held);
                    held = '{ST_EVICTED, victim[SLOT_W-1:0], slot_size[victim], 1'b0};
                    have_held = 1'b1;
                    count++;
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    expected_evictions.push_back(held);
                end
                else
                begin
                    expected_evictions.push_back('{ST_NONE, '0, '0, 1'b1});
                end
            end
        end
    endfunction

    function automatic void log_mismatch(input string what, input eviction_t want,
                                         input eviction_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: exp st=%0d sl=%0d by=%0d la=%0d got st=%0d sl=%0d by=%0d la=%0d",
                     $time, what, want.status, want.slot, want.bytes, want.last,
                     got.status, got.slot, got.bytes, got.last);
    endfunction

    always @(posedge clk)
    begin : word_check
        eviction_t got;
        eviction_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = m_axis_tuser;
            got.slot = m_axis_tdata[SLOT_W-1:0];
            got.bytes = m_axis_tdata[SLOT_W +: SIZE_W];
            got.last = m_axis_tlast;
            if (expected_evictions.size() == 0)
            begin
                log_mismatch("unexpected word", '0, got);
            end
            else
            begin
                want = expected_evictions.pop_front();
                if (got.status !== want.status || got.slot !== want.slot
                    || got.bytes !== want.bytes || got.last !== want.last)
                    log_mismatch("wrong word", want, got);
            end
            rx_hold = idle_on ? $urandom_range(0, STALL_MAX) : 0;
        end
        if (rst_n)
        begin
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_op(input table_op_t op);
        int gap;
        gap = idle_on ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, op.amount, op.can_evict, op.entry_bytes, op.used_nsec,
                         op.used_sec, op.created_nsec, op.created_sec, op.slot};
        s_axis_tuser <= op.action;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        predict_eviction(op);
    endtask

    task automatic put_entry(input int slot, input logic [31:0] c_sec, input logic [29:0] c_nsec,
                             input logic [31:0] u_sec, input logic [29:0] u_nsec,
                             input logic [31:0] size, input logic evictable);
        table_op_t op;
        op = '0;
        op.action = ACT_WRITE;
        op.slot = slot[SLOT_W-1:0];
        op.created_sec = c_sec;
        op.created_nsec = c_nsec;
        op.used_sec = u_sec;
        op.used_nsec = u_nsec;
        op.entry_bytes = size;
        op.can_evict = evictable;
        send_op(op);
    endtask

    task automatic drop_entry(input int slot);
        table_op_t op;
        op = '0;
        op.action = ACT_INVAL;
        op.slot = slot[SLOT_W-1:0];
        send_op(op);
    endtask

    task automatic request_free(input logic [TOTAL_W-1:0] amount);
        table_op_t op;
        op = '0;
        op.action = ACT_EVICT;
        op.amount = amount;
        send_op(op);
    endtask

    task automatic send_unused();
        table_op_t    op;
        logic [223:0] r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        op = r[$bits(table_op_t)-1:0];
        op.action = ACT_UNUSED;
        send_op(op);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_evictions.size() != 0)
            @(posedge clk);
        repeat (PAUSE_CYCLES) @(posedge clk);
    endtask

    task automatic set_policy(input logic fifo);
        wait_idle();
        policy_we <= 1'b1;
        policy_wdata <= fifo;
        @(posedge clk);
        policy_we <= 1'b0;
        order_fifo = fifo;
    endtask

    function automatic logic [31:0] rand_sec();
        return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
    endfunction

    function automatic logic [29:0] rand_nsec();
        logic [31:0] r;
        r = $urandom;
        return ($urandom_range(0, 1) == 0) ? r[29:0] : 30'($urandom_range(0, 2));
    endfunction

    function automatic logic [31:0] rand_size();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick < 4)
            return $urandom;
        else
            return $urandom_range(1, 4096);
    endfunction

    function automatic logic [TOTAL_W-1:0] rand_amount();
        logic [63:0] r;
        int pick;
        r = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1 && stored_bytes < TOTAL_MAX - 2000)
            return stored_bytes + $urandom_range(1, 1000);
        else if (pick == 2)
            return r[TOTAL_W-1:0];
        else if (pick < 7)
            return TOTAL_W'(r % ({27'b0, stored_bytes} + 64'd1));
        else
            return (stored_bytes < 5000) ? stored_bytes : $urandom_range(1, 5000);
    endfunction

    task automatic test_empty_table();
        set_policy(1'b0);
        request_free('0);
        request_free(37'd1);
        drop_entry(20);
        send_unused();
    endtask

    task automatic test_lru_order();
        put_entry(0, '1, '1, '1, '1, '1, 1'b1);
        put_entry(31, '0, '0, '0, '0, '0, 1'b1);
        put_entry(5, 32'd10, '1, 32'd7, 30'd1000000000, 32'd100, 1'b1);
        put_entry(3, 32'd7, 30'd5, 32'd7, 30'd5, 32'd200, 1'b1);
        put_entry(12, 32'd7, 30'd5, 32'd7, 30'd5, 32'd300, 1'b1);
        put_entry(9, '0, '0, '0, '0, 32'd400, 1'b0);
        put_entry(3, 32'd8, 30'd0, 32'd7, 30'd5, 32'd250, 1'b1);
        drop_entry(12);
        put_entry(12, 32'd7, 30'd5, 32'd7, 30'd5, 32'd300, 1'b1);
        request_free('0);
        request_free(TOTAL_MAX);
        request_free(37'd1);
        request_free(stored_bytes);
        request_free(37'd1);
        drop_entry(9);
    endtask

    task automatic test_fifo_order();
        set_policy(1'b1);
        put_entry(2, 32'd5, 30'd0, 32'd1, 30'd0, 32'd30, 1'b1);
        put_entry(1, 32'd3, 30'd0, 32'd9, 30'd0, 32'd10, 1'b1);
        put_entry(4, 32'd3, 30'd0, 32'd2, 30'd0, 32'd20, 1'b1);
        request_free(stored_bytes);
    endtask

    task automatic test_random_traffic();
        int sent;
        int pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_policy(phase[0]);
            idle_on = (phase != 3);
            sent = 0;
            while (sent < WORDS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                begin
                    send_unused();
                end
                else
                begin
                    sent++;
                    if (pick < 52)
                        put_entry($urandom_range(0, ENTRIES - 1), rand_sec(), rand_nsec(),
                                  rand_sec(), rand_nsec(), rand_size(),
                                  $urandom_range(0, 4) != 0);
                    else if (pick < 64)
                        drop_entry($urandom_range(0, ENTRIES - 1));
                    else
                        request_free(rand_amount());
                end
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic test_full_sweep();
        set_policy(1'($urandom_range(0, 1)));
        for (int i = 0; i < ENTRIES; i++)
            put_entry(i, rand_sec(), rand_nsec(), rand_sec(), rand_nsec(), rand_size(), 1'b1);
        request_free(stored_bytes);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_lru_order();
        test_fifo_order();
        test_random_traffic();
        test_full_sweep();
        wait_idle();
        repeat (FINAL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_evictions.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== lru_fifo_evictor_top.f =====
sv/lfe_pkg.sv
sv/lfe_table.sv
sv/lfe_cmp.sv
sv/lru_fifo_evictor_top.sv
tb/sv/lru_fifo_evictor_top_tb.sv
